@@ rtl/core/rx_frame_classifier_top_assert.svh @@
// assertion macros for the rx frame classifier
`ifndef RX_FRAME_CLASSIFIER_TOP_ASSERT_SVH
`define RX_FRAME_CLASSIFIER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RFC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rfc assertion failed");

// next-cycle implication, checked out of reset
`define RFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rfc assertion failed");

`endif

@@ rtl/core/rfc_pkg.sv @@
`default_nettype none
package rfc_pkg;

    localparam int unsigned MacW  = 48;
    localparam int unsigned IpW   = 32;
    localparam int unsigned PortW = 16;
    localparam int unsigned CmdW  = 16;
    localparam int unsigned PktW  = 32;
    localparam int unsigned PosW  = 6;
    localparam int unsigned KindW = 3;
    localparam int unsigned IdxW  = 2;

    localparam logic [KindW-1:0] KIND_NONE    = 3'd0;
    localparam logic [KindW-1:0] KIND_ARP_REQ = 3'd1;
    localparam logic [KindW-1:0] KIND_ARP_REP = 3'd2;
    localparam logic [KindW-1:0] KIND_ANSWER  = 3'd3;
    localparam logic [KindW-1:0] KIND_ACK     = 3'd4;

    localparam logic [IdxW-1:0] REG_OWN_MAC   = 2'd0;
    localparam logic [IdxW-1:0] REG_OWN_IP    = 2'd1;
    localparam logic [IdxW-1:0] REG_DATA_PORT = 2'd2;

    localparam logic [MacW-1:0]  OWN_MAC_RST   = 48'hFFFF_FFFF_FFFF;
    localparam logic [IpW-1:0]   OWN_IP_RST    = 32'hC0A8_7264;
    localparam logic [PortW-1:0] DATA_PORT_RST = 16'h7777;

    localparam logic [CmdW-1:0] ACK_COMMAND = 16'h3333;

    localparam int unsigned FLAG_DST_MAC  = 0;
    localparam int unsigned FLAG_ARP_HEAD = 1;
    localparam int unsigned FLAG_OP_REQ   = 2;
    localparam int unsigned FLAG_OP_REP   = 3;
    localparam int unsigned FLAG_DST_IP   = 4;
    localparam int unsigned FLAG_MAGIC    = 5;
    localparam int unsigned FLAG_ARP_TIP  = 6;
    localparam int unsigned FLAG_PORT     = 7;
    localparam logic [7:0]  FLAGS_ALL     = 8'hFF;

    typedef struct packed {
        logic [MacW-1:0]  own_mac;
        logic [IpW-1:0]   own_ip;
        logic [PortW-1:0] data_port;
    } rfc_cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rfc_beat_t;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [CmdW-1:0]  command;
        logic [PktW-1:0]  packet;
        logic [MacW-1:0]  peer_mac;
        logic [IpW-1:0]   peer_ip;
    } rfc_result_t;

    // arp header bytes at offsets 12..20
    function automatic logic [7:0] arp_head_byte(input logic [3:0] idx);
        logic [7:0] val;
        case (idx)
            4'd0:    val = 8'h08;
            4'd1:    val = 8'h06;
            4'd2:    val = 8'h00;
            4'd3:    val = 8'h01;
            4'd4:    val = 8'h08;
            4'd5:    val = 8'h00;
            4'd6:    val = 8'h06;
            4'd7:    val = 8'h04;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    // magic word bytes at offsets 42..45
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'hBA;
            2'd1:    val = 8'hDC;
            2'd2:    val = 8'hCD;
            default: val = 8'hAB;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/rx_frame_classifier_top.sv @@
// Receive frame classifier. Frame bytes enter on the s_ side, one beat per byte, s_tlast on
// the final byte, and one beat is taken every cycle. Each byte passes through an input
// register and is checked and captured as it leaves it; on the last byte one result beat
// goes into the output register once that is free or being read, and shows on the m_ side
// from there. The input stalls only when a last byte finds the output register still full.
// m_tuser carries the kind (0 none, 1 arp request, 2 arp reply, 3 command answer, 4 ack);
// fields that do not apply to the kind read as zero, and bytes past offset 51 are ignored.
// Write the cfg_ registers only while no frame is in flight; the block does not check this.
`default_nettype none
module rx_frame_classifier_top
    import rfc_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_we,
    input  wire logic [IdxW-1:0] cfg_index,
    input  wire logic [MacW-1:0] cfg_data,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [7:0]      s_tdata,    // frame_byte
    input  wire logic            s_tlast,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [127:0]         m_tdata,    // command_number, packet_number, peer_mac, peer_ip
    output logic [KindW-1:0]     m_tuser     // frame_kind
);

    rfc_cfg_t    cfg;
    rfc_beat_t   beat;
    rfc_result_t res;
    rfc_result_t res_out;
    logic        beat_valid;
    logic        pop;
    logic        res_valid;
    logic        out_ready;

    rfc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rfc_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .pop        (pop),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    rfc_parser u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .beat_valid (beat_valid),
        .beat       (beat),
        .out_ready  (out_ready),
        .pop        (pop),
        .res_valid  (res_valid),
        .res        (res)
    );

    rfc_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .res_out   (res_out)
    );

    assign m_tuser = res_out.kind;
    assign m_tdata = {res_out.peer_ip, res_out.peer_mac, res_out.packet, res_out.command};

endmodule
`default_nettype wire

@@ rtl/core/rfc_cfg_regs.sv @@
`default_nettype none
module rfc_cfg_regs
    import rfc_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_we,
    input  wire logic [IdxW-1:0] cfg_index,
    input  wire logic [MacW-1:0] cfg_data,
    output rfc_cfg_t             cfg
);

    rfc_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_mac   <= OWN_MAC_RST;
            cfg_reg.own_ip    <= OWN_IP_RST;
            cfg_reg.data_port <= DATA_PORT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_OWN_MAC:   cfg_reg.own_mac   <= cfg_data;
                REG_OWN_IP:    cfg_reg.own_ip    <= cfg_data[IpW-1:0];
                REG_DATA_PORT: cfg_reg.data_port <= cfg_data[PortW-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ rtl/core/rfc_in_reg.sv @@
`default_nettype none
module rfc_in_reg
    import rfc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    input  wire logic       pop,
    output logic            beat_valid,
    output rfc_beat_t       beat
);

    logic      valid_reg;
    rfc_beat_t beat_reg;

    assign s_tready = !valid_reg || pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            beat_reg.data <= s_tdata;
            beat_reg.last <= s_tlast;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule
`default_nettype wire

@@ rtl/core/rfc_parser.sv @@
`default_nettype none
module rfc_parser
    import rfc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire rfc_cfg_t cfg,
    input  wire logic  beat_valid,
    input  wire rfc_beat_t beat,
    input  wire logic  out_ready,
    output logic       pop,
    output logic       res_valid,
    output rfc_result_t res
);

    logic [PosW-1:0] pos_reg,   pos_next;
    logic [7:0]      flags_reg, flags_next;
    logic [MacW-1:0] mac_reg,   mac_next;
    logic [IpW-1:0]  ip_reg,    ip_next;
    logic [CmdW-1:0] cmd_reg,   cmd_next;
    logic [PktW-1:0] pkt_reg,   pkt_next;

    logic [7:0]      b;
    logic [2:0]      mac_sel;
    logic [1:0]      tip_sel;
    logic [1:0]      dip_sel;
    logic [1:0]      pkt_sel;
    logic [3:0]      head_sel;
    logic [1:0]      magic_sel;
    logic            advance;
    logic            is_req;
    logic            is_rep;
    logic            is_ans;

    assign b         = beat.data;
    assign mac_sel   = 3'd5 - pos_reg[2:0];
    assign tip_sel   = 2'd3 - 2'(pos_reg - 6'd30);
    assign dip_sel   = 2'd3 - 2'(pos_reg - 6'd38);
    assign pkt_sel   = 2'(pos_reg - 6'd48);
    assign head_sel  = 4'(pos_reg - 6'd12);
    assign magic_sel = 2'(pos_reg - 6'd42);

    assign advance = beat_valid && (!beat.last || out_ready);
    assign pop     = advance;

    always_comb begin
        flags_next = (pos_reg == '0) ? FLAGS_ALL : flags_reg;
        mac_next   = mac_reg;
        ip_next    = ip_reg;
        cmd_next   = cmd_reg;
        pkt_next   = pkt_reg;
        case (pos_reg) inside
            [6'd0:6'd5]: begin
                if (b != cfg.own_mac[{mac_sel, 3'b000} +: 8]) flags_next[FLAG_DST_MAC] = 1'b0;
            end
            [6'd12:6'd20]: begin
                if (b != arp_head_byte(head_sel)) flags_next[FLAG_ARP_HEAD] = 1'b0;
            end
            6'd21: begin
                if (b != 8'h01) flags_next[FLAG_OP_REQ] = 1'b0;
                if (b != 8'h02) flags_next[FLAG_OP_REP] = 1'b0;
            end
            [6'd22:6'd27]: mac_next = {mac_reg[MacW-9:0], b};
            [6'd28:6'd33]: begin
                if (pos_reg <= 6'd31) ip_next = {ip_reg[IpW-9:0], b};
                if (pos_reg >= 6'd30 && b != cfg.own_ip[{tip_sel, 3'b000} +: 8]) begin
                    flags_next[FLAG_ARP_TIP] = 1'b0;
                end
            end
            6'd36: begin
                if (b != cfg.data_port[15:8]) flags_next[FLAG_PORT] = 1'b0;
            end
            6'd37: begin
                if (b != cfg.data_port[7:0]) flags_next[FLAG_PORT] = 1'b0;
            end
            [6'd38:6'd41]: begin
                if (b != cfg.own_ip[{dip_sel, 3'b000} +: 8]) flags_next[FLAG_DST_IP] = 1'b0;
            end
            [6'd42:6'd45]: begin
                if (b != magic_byte(magic_sel)) flags_next[FLAG_MAGIC] = 1'b0;
            end
            6'd46: cmd_next[7:0]  = b;
            6'd47: cmd_next[15:8] = b;
            [6'd48:6'd51]: pkt_next[{pkt_sel, 3'b000} +: 8] = b;
            default: ;
        endcase
    end

    // arp classes win over the answer/ack check
    assign is_req = pos_reg >= 6'd41 && flags_next[FLAG_DST_IP] && flags_next[FLAG_ARP_HEAD]
                    && flags_next[FLAG_OP_REQ];
    assign is_rep = pos_reg >= 6'd41 && flags_next[FLAG_DST_IP] && flags_next[FLAG_ARP_HEAD]
                    && flags_next[FLAG_OP_REP] && flags_next[FLAG_DST_MAC];
    assign is_ans = pos_reg >= 6'd51 && flags_next[FLAG_MAGIC] && flags_next[FLAG_ARP_TIP]
                    && flags_next[FLAG_PORT];

    always_comb begin
        res = '0;
        if (is_req) begin
            res.kind     = KIND_ARP_REQ;
            res.peer_mac = mac_next;
            res.peer_ip  = ip_next;
        end else if (is_rep) begin
            res.kind     = KIND_ARP_REP;
            res.peer_mac = mac_next;
        end else if (is_ans) begin
            res.kind    = (cmd_next == ACK_COMMAND) ? KIND_ACK : KIND_ANSWER;
            res.command = cmd_next;
            res.packet  = pkt_next;
        end else begin
            res.kind = KIND_NONE;
        end
    end

    assign res_valid = advance && beat.last;

    always_comb begin
        if (beat.last) begin
            pos_next = '0;
        end else if (pos_reg != '1) begin
            pos_next = pos_reg + 1'b1;
        end else begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            flags_reg <= FLAGS_ALL;
            mac_reg   <= '0;
            ip_reg    <= '0;
            cmd_reg   <= '0;
            pkt_reg   <= '0;
        end else if (advance) begin
            pos_reg   <= pos_next;
            flags_reg <= beat.last ? FLAGS_ALL : flags_next;
            mac_reg   <= mac_next;
            ip_reg    <= ip_next;
            cmd_reg   <= cmd_next;
            pkt_reg   <= pkt_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/rfc_out_reg.sv @@
`default_nettype none
module rfc_out_reg
    import rfc_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   res_valid,
    input  wire rfc_result_t res,
    output logic        out_ready,
    output logic        m_tvalid,
    input  wire logic   m_tready,
    output rfc_result_t res_out
);

    logic        valid_reg;
    rfc_result_t res_reg;

    assign out_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_valid) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

endmodule
`default_nettype wire

@@ rtl/core/rfc_checker.sv @@
`default_nettype none
`include "rx_frame_classifier_top_assert.svh"
module rfc_checker
    import rfc_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [127:0]     m_tdata,
    input wire logic [KindW-1:0] m_tuser
);

    `RFC_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `RFC_ASSERT_NOW(a_none_zero, aclk, aresetn, m_tvalid && m_tuser == KIND_NONE, m_tdata == '0)
    `RFC_ASSERT_NOW(a_arp_no_cmd, aclk, aresetn, m_tvalid && (m_tuser == KIND_ARP_REQ || m_tuser == KIND_ARP_REP), m_tdata[47:0] == '0)
    `RFC_ASSERT_NOW(a_ans_no_peer, aclk, aresetn, m_tvalid && (m_tuser == KIND_ANSWER || m_tuser == KIND_ACK), m_tdata[127:48] == '0)

endmodule

bind rx_frame_classifier_top rfc_checker u_rfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

@@ test/rx_frame_classifier_checker.sv @@
module rx_frame_classifier_checker
    import rfc_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_we,
    input  wire logic [IdxW-1:0] cfg_index,
    input  wire logic [MacW-1:0] cfg_data,
    input  wire logic            s_tvalid,
    input  wire logic            s_tready,
    input  wire logic [7:0]      s_tdata,    // frame_byte
    input  wire logic            s_tlast,
    input  wire logic            m_tvalid,
    input  wire logic            m_tready,
    input  wire logic [127:0]    m_tdata,    // command_number, packet_number, peer_mac, peer_ip
    input  wire logic [KindW-1:0] m_tuser,   // frame_kind
    output int                   fail_count,
    output int                   pending
);

    localparam logic [71:0] ARP_HEADER = 72'h08_06_00_01_08_00_06_04_00;
    localparam logic [31:0] MAGIC_WORD = 32'hBA_DC_CD_AB;

    logic [MacW-1:0]  cfg_mac;
    logic [IpW-1:0]   cfg_ip;
    logic [PortW-1:0] cfg_port;

    logic [PosW-1:0]  frame_pos;
    logic [7:0]       frame_matches;
    logic [CmdW-1:0]  cap_command;
    logic [PktW-1:0]  cap_packet;
    logic [MacW-1:0]  cap_mac;
    logic [IpW-1:0]   cap_ip;

    rfc_result_t      expected_results[$];
    rfc_result_t      want;
    rfc_result_t      got;
    int               errors;

    task automatic clear_on(input logic mismatch, input int flag);
        if (mismatch) frame_matches[flag] = 1'b0;
    endtask

    task automatic classify_byte(input logic [7:0] b, input logic last);
        int          p;
        rfc_result_t res;
        p = frame_pos;
        if (p == 0) frame_matches = FLAGS_ALL;
        if (p < 6) begin
            clear_on(b != cfg_mac[8*(5-p) +: 8], FLAG_DST_MAC);
        end else if (p >= 12 && p <= 20) begin
            clear_on(b != ARP_HEADER[8*(20-p) +: 8], FLAG_ARP_HEAD);
        end else if (p == 21) begin
            clear_on(b != 8'h01, FLAG_OP_REQ);
            clear_on(b != 8'h02, FLAG_OP_REP);
        end else if (p >= 22 && p <= 27) begin
            cap_mac = {cap_mac[MacW-9:0], b};
        end else if (p >= 28 && p <= 33) begin
            if (p <= 31) cap_ip = {cap_ip[IpW-9:0], b};
            if (p >= 30) clear_on(b != cfg_ip[8*(33-p) +: 8], FLAG_ARP_TIP);
        end else if (p == 36) begin
            clear_on(b != cfg_port[15:8], FLAG_PORT);
        end else if (p == 37) begin
            clear_on(b != cfg_port[7:0], FLAG_PORT);
        end else if (p >= 38 && p <= 41) begin
            clear_on(b != cfg_ip[8*(41-p) +: 8], FLAG_DST_IP);
        end else if (p >= 42 && p <= 45) begin
            clear_on(b != MAGIC_WORD[8*(45-p) +: 8], FLAG_MAGIC);
        end else if (p == 46) begin
            cap_command[7:0] = b;
        end else if (p == 47) begin
            cap_command[15:8] = b;
        end else if (p >= 48 && p <= 51) begin
            cap_packet[8*(p-48) +: 8] = b;
        end

        if (!last) begin
            if (p < 63) frame_pos = frame_pos + 1'b1;
        end else begin
            res = '0;
            if (p >= 41 && frame_matches[FLAG_ARP_HEAD] && frame_matches[FLAG_DST_IP]
                    && frame_matches[FLAG_OP_REQ]) begin
                res.kind     = KIND_ARP_REQ;
                res.peer_mac = cap_mac;
                res.peer_ip  = cap_ip;
            end else if (p >= 41 && frame_matches[FLAG_DST_MAC] && frame_matches[FLAG_ARP_HEAD]
                    && frame_matches[FLAG_OP_REP] && frame_matches[FLAG_DST_IP]) begin
                res.kind     = KIND_ARP_REP;
                res.peer_mac = cap_mac;
            end else if (p >= 51 && frame_matches[FLAG_MAGIC] && frame_matches[FLAG_ARP_TIP]
                    && frame_matches[FLAG_PORT]) begin
                res.kind    = (cap_command == ACK_COMMAND) ? KIND_ACK : KIND_ANSWER;
                res.command = cap_command;
                res.packet  = cap_packet;
            end
            expected_results.push_back(res);
            frame_pos     = '0;
            frame_matches = FLAGS_ALL;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_mac       = OWN_MAC_RST;
            cfg_ip        = OWN_IP_RST;
            cfg_port      = DATA_PORT_RST;
            frame_pos     = '0;
            frame_matches = FLAGS_ALL;
            cap_command   = '0;
            cap_packet    = '0;
            cap_mac       = '0;
            cap_ip        = '0;
            expected_results.delete();
            errors        = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_OWN_MAC:   cfg_mac  = cfg_data;
                    REG_OWN_IP:    cfg_ip   = cfg_data[IpW-1:0];
                    REG_DATA_PORT: cfg_port = cfg_data[PortW-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) classify_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got.kind     = m_tuser;
                got.command  = m_tdata[15:0];
                got.packet   = m_tdata[47:16];
                got.peer_mac = m_tdata[95:48];
                got.peer_ip  = m_tdata[127:96];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got kind %0d",
                             $time, got.kind);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("frame_kind", want.kind, got.kind);
                    check_field("command_number", want.command, got.command);
                    check_field("packet_number", want.packet, got.packet);
                    check_field("peer_mac", want.peer_mac, got.peer_mac);
                    check_field("peer_ip", want.peer_ip, got.peer_ip);
                end
            end
        end
        fail_count <= errors;
        pending    <= expected_results.size();
    end

endmodule

@@ test/tb_rx_frame_classifier_top.sv @@
module tb_rx_frame_classifier_top;
    import rfc_pkg::*;

    localparam logic [IdxW-1:0] REG_UNUSED = 2'd3;

    localparam int STYLE_NOISE   = 0;
    localparam int STYLE_ARP_REQ = 1;
    localparam int STYLE_ARP_REP = 2;
    localparam int STYLE_ANSWER  = 3;
    localparam int STYLE_ACK     = 4;
    localparam int STYLE_BOTH    = 5;

    logic             aclk;
    logic             aresetn;
    logic             cfg_we;
    logic [IdxW-1:0]  cfg_index;
    logic [MacW-1:0]  cfg_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic             s_tlast;
    logic             m_tvalid;
    logic             m_tready;
    logic [127:0]     m_tdata;
    logic [KindW-1:0] m_tuser;
    int               fail_count;
    int               pending;

    logic [MacW-1:0]  own_mac;
    logic [IpW-1:0]   own_ip;
    logic [PortW-1:0] own_port;
    logic [7:0]       frame_buf[$];
    int               idle_pct;
    logic             hold_req;

    rx_frame_classifier_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    rx_frame_classifier_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    initial begin
        #2000000;
        $display("tb_rx_frame_classifier_top failed");
        $finish;
    end

    // receiver: random stalls plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [MacW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_OWN_MAC:   own_mac  = val;
            REG_OWN_IP:    own_ip   = val[IpW-1:0];
            REG_DATA_PORT: own_port = val[PortW-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_beat(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic put_byte(input int pos, input logic [7:0] v);
        if (pos < frame_buf.size()) frame_buf[pos] = v;
    endtask

    task automatic build_frame(input int style, input int len);
        logic [CmdW-1:0] cmd;
        int              sel;
        frame_buf.delete();
        repeat (len) frame_buf.push_back(8'($urandom_range(0, 255)));
        if (style == STYLE_ARP_REQ || style == STYLE_ARP_REP || style == STYLE_BOTH) begin
            sel = (style == STYLE_ARP_REQ) ? $urandom_range(0, 2) : 1;
            for (int k = 0; k < 6; k++) begin
                if (sel == 0) put_byte(k, 8'hFF);
                else if (sel == 1) put_byte(k, own_mac[8*(5-k) +: 8]);
            end
            for (int k = 0; k < 9; k++) put_byte(12 + k, arp_head_byte(4'(k)));
            put_byte(21, (style == STYLE_ARP_REQ) ? 8'h01 : 8'h02);
            for (int k = 0; k < 4; k++) put_byte(38 + k, own_ip[8*(3-k) +: 8]);
        end
        if (style == STYLE_ANSWER || style == STYLE_ACK || style == STYLE_BOTH) begin
            cmd = (style == STYLE_ACK) ? ACK_COMMAND : CmdW'($urandom_range(0, 65535));
            for (int k = 0; k < 4; k++) begin
                put_byte(30 + k, own_ip[8*(3-k) +: 8]);
                put_byte(42 + k, magic_byte(2'(k)));
            end
            put_byte(36, own_port[15:8]);
            put_byte(37, own_port[7:0]);
            put_byte(46, cmd[7:0]);
            put_byte(47, cmd[15:8]);
        end
    endtask

    task automatic directed_frame(input int style, input int len);
        build_frame(style, len);
        send_frame();
    endtask

    task automatic random_frame();
        int r;
        int style;
        int len;
        int pos;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            style = STYLE_NOISE;
            len   = $urandom_range(1, 70);
        end else begin
            style = $urandom_range(STYLE_ARP_REQ, STYLE_BOTH);
            if (style == STYLE_ARP_REQ || style == STYLE_ARP_REP) len = $urandom_range(42, 66);
            else len = $urandom_range(52, 70);
            if (r >= 88) len = $urandom_range(1, 51);
        end
        build_frame(style, len);
        if (style != STYLE_NOISE && $urandom_range(0, 3) == 0) begin
            pos = $urandom_range(0, ((len < 52) ? len : 52) - 1);
            frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(1, 255));
        end
        send_frame();
    endtask

    // drain all results, then let the pipeline go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        own_mac   = OWN_MAC_RST;
        own_ip    = OWN_IP_RST;
        own_port  = DATA_PORT_RST;
        idle_pct  = 26;
        hold_req  = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed frames at reset settings
        frame_buf = '{8'h00};
        send_frame();
        frame_buf = '{8'hFF};
        send_frame();
        directed_frame(STYLE_ARP_REQ, 42);
        directed_frame(STYLE_ARP_REQ, 41);
        directed_frame(STYLE_ARP_REP, 42);
        directed_frame(STYLE_ANSWER, 52);
        directed_frame(STYLE_ANSWER, 51);
        directed_frame(STYLE_ACK, 52);
        settle();

        // all-zero settings
        write_reg(REG_OWN_MAC, '0);
        write_reg(REG_OWN_IP, '0);
        write_reg(REG_DATA_PORT, '0);
        random_frame();
        settle();

        // all-ones settings with a stretch of no idling
        write_reg(REG_OWN_MAC, '1);
        write_reg(REG_OWN_IP, '1);
        write_reg(REG_DATA_PORT, '1);
        idle_pct = 0;
        repeat (3) random_frame();
        idle_pct = 26;
        settle();

        // random settings, an ignored index, and a long receiver hold-off
        write_reg(REG_OWN_MAC, MacW'({$urandom, $urandom}));
        write_reg(REG_OWN_IP, MacW'($urandom));
        write_reg(REG_DATA_PORT, MacW'($urandom_range(0, 65535)));
        write_reg(REG_UNUSED, MacW'({$urandom, $urandom}));
        hold_req = 1'b1;
        repeat (12) begin
            build_frame(STYLE_NOISE, $urandom_range(1, 3));
            send_frame();
        end
        random_frame();
        settle();

        // back to reset values
        write_reg(REG_OWN_MAC, OWN_MAC_RST);
        write_reg(REG_OWN_IP, OWN_IP_RST);
        write_reg(REG_DATA_PORT, DATA_PORT_RST);
        random_frame();
        settle();

        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_rx_frame_classifier_top passed");
        end else begin
            $display("tb_rx_frame_classifier_top failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rfc_pkg.sv
rtl/core/rfc_cfg_regs.sv
rtl/core/rfc_in_reg.sv
rtl/core/rfc_parser.sv
rtl/core/rfc_out_reg.sv
rtl/core/rx_frame_classifier_top.sv
rtl/core/rfc_checker.sv
test/rx_frame_classifier_checker.sv
test/tb_rx_frame_classifier_top.sv
